/* design/u8v_pkg.sv */
// Shared types and constants for the UTF-8 stream validator.
`timescale 1ns / 1ps

package u8v_pkg;

    // Byte value boundaries used by the classifier
    localparam logic [7:0] BYTE_CONT_LO  = 8'h80;
    localparam logic [7:0] BYTE_CONT_HI  = 8'hBF;
    localparam logic [7:0] BYTE_CONT_9F  = 8'h9F;
    localparam logic [7:0] BYTE_CONT_8F  = 8'h8F;
    localparam logic [7:0] BYTE_CONT_90  = 8'h90;
    localparam logic [7:0] BYTE_CONT_A0  = 8'hA0;
    localparam logic [7:0] BYTE_LEAD2_LO = 8'hC2;
    localparam logic [7:0] BYTE_LEAD2_HI = 8'hDF;
    localparam logic [7:0] BYTE_LEAD3_LO = 8'hE0;
    localparam logic [7:0] BYTE_LEAD3_ED = 8'hED;
    localparam logic [7:0] BYTE_LEAD3_HI = 8'hEF;
    localparam logic [7:0] BYTE_LEAD4_LO = 8'hF0;
    localparam logic [7:0] BYTE_LEAD4_HI = 8'hF4;

    // Range rule for the first continuation byte of a sequence
    typedef logic [2:0] u8v_rule_t;
    localparam u8v_rule_t RULE_ANY = 3'd0;  // 80..BF
    localparam u8v_rule_t RULE_E0  = 3'd1;  // A0..BF
    localparam u8v_rule_t RULE_ED  = 3'd2;  // 80..9F
    localparam u8v_rule_t RULE_F0  = 3'd3;  // 90..BF
    localparam u8v_rule_t RULE_F4  = 3'd4;  // 80..8F
    localparam int        RULE_COUNT = 5;

    typedef logic [1:0] u8v_pending_t;

    // Byte class seen as a leading byte
    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_CONT,
        KIND_BAD
    } u8v_kind_t;

    // Classified byte passed from front to back
    typedef struct packed {
        u8v_kind_t              kind;
        u8v_rule_t              rule;     // rule a leading byte imposes
        logic [RULE_COUNT-1:0]  cont_ok;  // byte passes rule n as continuation
        logic                   eom;
    } u8v_item_t;

endpackage

/* design/u8v_if.sv */
// Handshake channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps

interface u8v_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface u8v_out_if;
    logic valid;
    logic ready;
    logic message_valid;

    modport source (output valid, output message_valid, input ready);
    modport sink   (input valid, input message_valid, output ready);
endinterface

/* design/u8v_front.sv */
// Front stage: accepts bytes and classifies them into a registered item.
`timescale 1ns / 1ps

module u8v_front
    import u8v_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    u8v_in_if.sink    byte_in,
    output logic      push_valid,
    input  logic      push_ready,
    output u8v_item_t push_item
);

    logic      stage_valid_reg;
    logic      stage_valid_next;
    u8v_item_t stage_item_reg;
    u8v_item_t class_item;
    logic      accept;
    logic [7:0] b;

    assign b = byte_in.data_byte;

    // Classify the incoming byte
    always_comb
    begin
        class_item      = '0;
        class_item.eom  = byte_in.end_of_message;
        class_item.rule = RULE_ANY;
        if (b inside {[8'h00:8'h7F]})
        begin
            class_item.kind = KIND_ASCII;
        end
        else if (b inside {[BYTE_CONT_LO:BYTE_CONT_HI]})
        begin
            class_item.kind = KIND_CONT;
        end
        else if (b inside {[BYTE_LEAD2_LO:BYTE_LEAD2_HI]})
        begin
            class_item.kind = KIND_LEAD2;
        end
        else if (b inside {[BYTE_LEAD3_LO:BYTE_LEAD3_HI]})
        begin
            class_item.kind = KIND_LEAD3;
            if (b == BYTE_LEAD3_LO)
                class_item.rule = RULE_E0;
            else if (b == BYTE_LEAD3_ED)
                class_item.rule = RULE_ED;
        end
        else if (b inside {[BYTE_LEAD4_LO:BYTE_LEAD4_HI]})
        begin
            class_item.kind = KIND_LEAD4;
            if (b == BYTE_LEAD4_LO)
                class_item.rule = RULE_F0;
            else if (b == BYTE_LEAD4_HI)
                class_item.rule = RULE_F4;
        end
        else
        begin
            class_item.kind = KIND_BAD;
        end

        // Continuation checks for every first-byte rule
        class_item.cont_ok[RULE_ANY] = b inside {[BYTE_CONT_LO:BYTE_CONT_HI]};
        class_item.cont_ok[RULE_E0]  = b inside {[BYTE_CONT_A0:BYTE_CONT_HI]};
        class_item.cont_ok[RULE_ED]  = b inside {[BYTE_CONT_LO:BYTE_CONT_9F]};
        class_item.cont_ok[RULE_F0]  = b inside {[BYTE_CONT_90:BYTE_CONT_HI]};
        class_item.cont_ok[RULE_F4]  = b inside {[BYTE_CONT_LO:BYTE_CONT_8F]};
    end

    // Stage register: refills in the same cycle it drains
    assign byte_in.ready = !stage_valid_reg || push_ready;
    assign accept        = byte_in.valid && byte_in.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (push_ready)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_item_reg <= class_item;
    end

    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;

endmodule

/* design/u8v_queue.sv */
// Small FIFO of classified items between front and back.
`timescale 1ns / 1ps

module u8v_queue
    import u8v_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  u8v_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output u8v_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    u8v_item_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

`ifndef SYNTHESIS
    // Fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_FULL)
        else $error("queue count above depth");

    // Pointers stay in step with the count
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_FULL) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step with count");
`endif

endmodule

/* design/u8v_back.sv */
// Back stage: sequence tracking, sticky error and registered verdict.
`timescale 1ns / 1ps

module u8v_back
    import u8v_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  u8v_item_t pop_item,
    u8v_out_if.source result_out
);

    u8v_pending_t pending_reg;
    u8v_pending_t pending_next;
    u8v_rule_t    rule_reg;
    u8v_rule_t    rule_next;
    logic         error_reg;
    logic         error_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         verdict_reg;
    logic         do_pop;
    logic         cont_pass;

    assign pop_ready = !out_valid_reg || result_out.ready;
    assign do_pop    = pop_valid && pop_ready;

    // Continuation check under the current first-byte rule
    always_comb
    begin
        case (rule_reg)
            RULE_E0: cont_pass = pop_item.cont_ok[RULE_E0];
            RULE_ED: cont_pass = pop_item.cont_ok[RULE_ED];
            RULE_F0: cont_pass = pop_item.cont_ok[RULE_F0];
            RULE_F4: cont_pass = pop_item.cont_ok[RULE_F4];
            default: cont_pass = pop_item.cont_ok[RULE_ANY];
        endcase
    end

    // Sequence state update for one transaction
    always_comb
    begin
        pending_next = pending_reg;
        rule_next    = rule_reg;
        error_next   = error_reg;
        if (pending_reg != '0)
        begin
            if (cont_pass)
                pending_next = pending_reg - 1'b1;
            else
            begin
                error_next   = 1'b1;
                pending_next = '0;
            end
            rule_next = RULE_ANY;
        end
        else
        begin
            case (pop_item.kind)
                KIND_ASCII: ;
                KIND_LEAD2:
                begin
                    pending_next = 2'd1;
                    rule_next    = RULE_ANY;
                end
                KIND_LEAD3:
                begin
                    pending_next = 2'd2;
                    rule_next    = pop_item.rule;
                end
                KIND_LEAD4:
                begin
                    pending_next = 2'd3;
                    rule_next    = pop_item.rule;
                end
                default: error_next = 1'b1;
            endcase
        end
    end

    assign out_valid_next = (do_pop && pop_item.eom) ||
                            (out_valid_reg && !result_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            rule_reg      <= RULE_ANY;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (do_pop)
            begin
                if (pop_item.eom)
                begin
                    pending_reg <= '0;
                    rule_reg    <= RULE_ANY;
                    error_reg   <= 1'b0;
                end
                else
                begin
                    pending_reg <= pending_next;
                    rule_reg    <= rule_next;
                    error_reg   <= error_next;
                end
            end
        end
    end

    // Verdict register, loaded at the last byte of a message
    always_ff @(posedge clk)
    begin
        if (do_pop && pop_item.eom)
            verdict_reg <= !error_next && (pending_next == '0);
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.message_valid = verdict_reg;

`ifndef SYNTHESIS
    // A narrowed rule only lives while two or more continuations are owed
    assert property (@(posedge clk) disable iff (!rst_n)
        (rule_reg != RULE_ANY) |-> (pending_reg >= 2'd2))
        else $error("narrowed rule without open multi-byte sequence");

    // Message end clears all sequence state
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && pop_item.eom) |=> (pending_reg == '0 && !error_reg && rule_reg == RULE_ANY))
        else $error("state not cleared after last byte");

    // A last byte always produces a pending verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && pop_item.eom) |=> out_valid_reg)
        else $error("verdict missing after last byte");
`endif

endmodule

/* design/utf8_stream_validator.sv */
// Top level of the UTF-8 stream validator.
`timescale 1ns / 1ps

// Checks a byte stream for well-formed UTF-8, one message at a time. Bytes
// arrive on byte_in with end_of_message marking each message's last byte;
// for that byte, and only that byte, one transaction leaves on result_out
// with message_valid = 1 when the message had no bad leading byte, no bad
// continuation and no sequence cut off at the end. The block sustains one
// byte per clock while result_out takes its results: a classification
// register, a small item queue and the sequence tracker each pass one item
// a cycle unless held, and the verdict sits in its own output register so
// a stalled result does not stop byte intake until the queue and the
// classification register are full. The verdict for a last byte passes the
// classification register, a queue slot and the verdict register on its
// way to result_out. The queue depth is set by QUEUE_DEPTH.

module utf8_stream_validator
    import u8v_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    u8v_in_if.sink     byte_in,
    u8v_out_if.source  result_out
);

    logic      push_valid;
    logic      push_ready;
    u8v_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    u8v_item_t pop_item;

    u8v_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    u8v_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    u8v_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .result_out (result_out)
    );

endmodule

/* verif/tb_utf8_stream_validator.sv */
// Testbench for utf8_stream_validator: directed and random messages checked against a UTF-8 tracker.
`timescale 1ns / 1ps

module tb_utf8_stream_validator;
    import u8v_pkg::*;

    typedef logic [7:0] msg_bytes_t [$];

    logic clk = 1'b0;
    logic rst_n;

    u8v_in_if  byte_in();
    u8v_out_if result_out();

    utf8_stream_validator dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .result_out (result_out)
    );

    // Tracker state, mirrors the sequence decoder
    u8v_pending_t pend_cnt;
    u8v_rule_t    first_cont_rule;
    logic         msg_err;

    bit verdict_q [$];       // verdicts owed, oldest first
    int mismatch_count;
    bit src_idle;            // byte side inserts random gaps
    bit dst_idle;            // result side stalls at random
    msg_bytes_t dmsg;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Generous run limit
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Does byte b pass as first continuation under the given rule
    function automatic bit cont_in_range(input logic [7:0] b, input u8v_rule_t rule);
        case (rule)
            RULE_E0: return b >= BYTE_CONT_A0 && b <= BYTE_CONT_HI;
            RULE_ED: return b >= BYTE_CONT_LO && b <= BYTE_CONT_9F;
            RULE_F0: return b >= BYTE_CONT_90 && b <= BYTE_CONT_HI;
            RULE_F4: return b >= BYTE_CONT_LO && b <= BYTE_CONT_8F;
            default: return b >= BYTE_CONT_LO && b <= BYTE_CONT_HI;
        endcase
    endfunction

    // Advance the tracker by one accepted byte; queue a verdict at end of message
    function void track_byte(input logic [7:0] b, input logic last);
        if (pend_cnt != 2'd0)
        begin
            if (cont_in_range(b, first_cont_rule))
                pend_cnt = pend_cnt - 2'd1;
            else
            begin
                msg_err  = 1'b1;
                pend_cnt = 2'd0;
            end
            first_cont_rule = RULE_ANY;
        end
        else if (b < BYTE_CONT_LO)
        begin
            // ASCII stands alone
        end
        else if (b >= BYTE_LEAD2_LO && b <= BYTE_LEAD2_HI)
        begin
            pend_cnt        = 2'd1;
            first_cont_rule = RULE_ANY;
        end
        else if (b >= BYTE_LEAD3_LO && b <= BYTE_LEAD3_HI)
        begin
            pend_cnt        = 2'd2;
            first_cont_rule = (b == BYTE_LEAD3_LO) ? RULE_E0 :
                              (b == BYTE_LEAD3_ED) ? RULE_ED : RULE_ANY;
        end
        else if (b >= BYTE_LEAD4_LO && b <= BYTE_LEAD4_HI)
        begin
            pend_cnt        = 2'd3;
            first_cont_rule = (b == BYTE_LEAD4_LO) ? RULE_F0 :
                              (b == BYTE_LEAD4_HI) ? RULE_F4 : RULE_ANY;
        end
        else
            msg_err = 1'b1;   // C0, C1, F5..FF or stray continuation

        if (last)
        begin
            verdict_q.push_back(!msg_err && pend_cnt == 2'd0);
            pend_cnt        = 2'd0;
            first_cont_rule = RULE_ANY;
            msg_err         = 1'b0;
        end
    endfunction

    // Drive one byte transaction; valid stays high when the next byte follows at once
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        if (gap != 0)
        begin
            byte_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_in.valid          <= 1'b1;
        byte_in.data_byte      <= b;
        byte_in.end_of_message <= last;
        do
            @(posedge clk);
        while (!byte_in.ready);
        track_byte(b, last);
    endtask

    task automatic send_message(input msg_bytes_t msg);
        foreach (msg[i])
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    // Append one well-formed character with random content
    function automatic void add_char(ref msg_bytes_t m);
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        int extra;
        lo = BYTE_CONT_LO;
        hi = BYTE_CONT_HI;
        case ($urandom_range(0, 3))
            0:
            begin
                lead  = 8'($urandom_range(0, 127));
                extra = 0;
            end
            1:
            begin
                lead  = 8'($urandom_range(BYTE_LEAD2_LO, BYTE_LEAD2_HI));
                extra = 1;
            end
            2:
            begin
                // lean on the leads with narrowed second bytes
                case ($urandom_range(0, 2))
                    0:       lead = BYTE_LEAD3_LO;
                    1:       lead = BYTE_LEAD3_ED;
                    default: lead = 8'($urandom_range(BYTE_LEAD3_LO, BYTE_LEAD3_HI));
                endcase
                extra = 2;
                if (lead == BYTE_LEAD3_LO) lo = BYTE_CONT_A0;
                if (lead == BYTE_LEAD3_ED) hi = BYTE_CONT_9F;
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       lead = BYTE_LEAD4_LO;
                    1:       lead = BYTE_LEAD4_HI;
                    default: lead = 8'($urandom_range(BYTE_LEAD4_LO, BYTE_LEAD4_HI));
                endcase
                extra = 3;
                if (lead == BYTE_LEAD4_LO) lo = BYTE_CONT_90;
                if (lead == BYTE_LEAD4_HI) hi = BYTE_CONT_8F;
            end
        endcase
        m.push_back(lead);
        for (int k = 0; k < extra; k++)
        begin
            if (k == 0)
                m.push_back(8'($urandom_range(lo, hi)));
            else
                m.push_back(8'($urandom_range(BYTE_CONT_LO, BYTE_CONT_HI)));
        end
    endfunction

    // A byte near one of the range boundaries
    function automatic logic [7:0] edge_byte();
        logic [7:0] picks [17];
        picks = '{8'h00, 8'h7F, 8'h80, 8'h8F, 8'h90, 8'h9F, 8'hA0, 8'hBF, 8'hC0,
                  8'hC1, 8'hC2, 8'hDF, 8'hE0, 8'hEF, 8'hF0, 8'hF4, 8'hF5};
        if ($urandom_range(0, 17) == 17)
            return 8'hFF;
        return picks[$urandom_range(0, 16)];
    endfunction

    // Mostly well-formed messages, some with a damaged byte, cut off early or replaced by noise
    function automatic void build_message(ref msg_bytes_t m);
        int n_chars;
        int sel;
        int len;
        m.delete();
        n_chars = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6);
        for (int c = 0; c < n_chars; c++)
            add_char(m);
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            // left well-formed
        end
        else if (sel < 72)
            m[$urandom_range(0, m.size() - 1)] = edge_byte();
        else if (sel < 80)
            m[$urandom_range(0, m.size() - 1)] = 8'($urandom_range(0, 255));
        else if (sel < 90)
        begin
            if (m.size() > 1)
            begin
                len = $urandom_range(1, m.size() - 1);
                while (m.size() > len)
                    void'(m.pop_back());
            end
        end
        else
        begin
            // pure noise
            m.delete();
            len = $urandom_range(1, 5);
            for (int k = 0; k < len; k++)
                m.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic run_random_messages(input int n_items, input bit vary_idle);
        msg_bytes_t msg;
        int sent;
        int stretch;
        sent    = 0;
        stretch = 0;
        while (sent < n_items)
        begin
            // change idling pattern every few dozen bytes
            if (vary_idle && sent >= stretch)
            begin
                src_idle = ($urandom_range(0, 3) != 0);
                dst_idle = ($urandom_range(0, 3) != 0);
                stretch  = sent + $urandom_range(20, 80);
            end
            build_message(msg);
            send_message(msg);
            sent += msg.size();
        end
    endtask

    task automatic test_single_bytes();
        dmsg = '{8'h00};
        send_message(dmsg);
        dmsg = '{8'h7F};
        send_message(dmsg);
    endtask

    task automatic test_two_byte_sequences();
        dmsg = '{8'hC2, 8'h80};
        send_message(dmsg);
        dmsg = '{8'hDF, 8'hBF};
        send_message(dmsg);
    endtask

    // Second byte narrowed after E0, ED, F0 and F4
    task automatic test_narrowed_ranges();
        dmsg = '{8'hE0, 8'h9F, 8'h80};
        send_message(dmsg);
        dmsg = '{8'hED, 8'h9F, 8'hBF};
        send_message(dmsg);
        dmsg = '{8'hF0, 8'h90, 8'h80, 8'h80};
        send_message(dmsg);
        dmsg = '{8'hF4, 8'h90};
        send_message(dmsg);
    endtask

    task automatic test_bad_leading_bytes();
        dmsg = '{8'hC0};
        send_message(dmsg);
        dmsg = '{8'hF5};
        send_message(dmsg);
        dmsg = '{8'hFF};
        send_message(dmsg);
        dmsg = '{8'h80};
        send_message(dmsg);
    endtask

    task automatic test_cut_off_sequence();
        dmsg = '{8'hE1, 8'h80};
        send_message(dmsg);
    endtask

    // Full rate on both sides
    task automatic test_back_to_back();
        src_idle = 1'b0;
        dst_idle = 1'b0;
        run_random_messages(150, 1'b0);
    endtask

    task automatic test_random_traffic();
        run_random_messages(750, 1'b1);
    endtask

    // Result side: random stall before each transaction
    initial
    begin
        int stall;
        result_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = dst_idle ? $urandom_range(0, 7) : 0;
            if (stall != 0)
            begin
                result_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_out.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_out.valid && result_out.ready));
        end
    end

    // Compare each result transaction with the oldest owed verdict
    initial
    begin
        bit exp_verdict;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_out.valid && result_out.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("message_valid: expected no transaction, actual %0b",
                           result_out.message_valid);
                    mismatch_count++;
                end
                else
                begin
                    exp_verdict = verdict_q.pop_front();
                    if (result_out.message_valid !== exp_verdict)
                    begin
                        $error("message_valid: expected %0b, actual %0b",
                               exp_verdict, result_out.message_valid);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        mismatch_count  = 0;
        pend_cnt        = 2'd0;
        first_cont_rule = RULE_ANY;
        msg_err         = 1'b0;
        src_idle        = 1'b1;
        dst_idle        = 1'b1;
        rst_n                  <= 1'b0;
        byte_in.valid          <= 1'b0;
        byte_in.data_byte      <= 8'h00;
        byte_in.end_of_message <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_bytes();
        test_two_byte_sequences();
        test_narrowed_ranges();
        test_bad_leading_bytes();
        test_cut_off_sequence();
        test_back_to_back();
        test_random_traffic();

        byte_in.valid <= 1'b0;
        dst_idle = 1'b1;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
design/u8v_pkg.sv
design/u8v_if.sv
design/u8v_front.sv
design/u8v_queue.sv
design/u8v_back.sv
design/utf8_stream_validator.sv
verif/tb_utf8_stream_validator.sv
